>>> hdl/sme_pkg.sv
package sme_pkg;

   typedef enum logic [2:0] {
      REQ_SET_RECT   = 3'd0,
      REQ_CLEAR_RECT = 3'd1,
      REQ_SELECT_ALL = 3'd2,
      REQ_CLEAR_ALL  = 3'd3,
      REQ_QUERY_PIX  = 3'd4,
      REQ_QUERY_BOX  = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      OP_NOP   = 2'd0,
      OP_FILL  = 2'd1,
      OP_PIXEL = 2'd2,
      OP_BOX   = 2'd3
   } op_type;

   localparam int CSR_WIDTH  = 0;
   localparam int CSR_HEIGHT = 1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_CLEAR = 2'd1,
      ST_WORK  = 2'd2,
      ST_EMIT  = 2'd3
   } exec_state_type;

endpackage

>>> hdl/sme_front.sv
module sme_front #(
   parameter int XW = 8,
   parameter int YW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_type,
   input  logic signed [9:0]    pos_x,
   input  logic signed [9:0]    pos_y,
   input  logic [9:0]           rect_w,
   input  logic [9:0]           rect_h,
   input  logic [XW:0]          eff_w,
   input  logic [YW:0]          eff_h,
   input  logic                 flush,
   input  logic                 deq,
   output logic                 q_full,
   output logic                 q_valid,
   output sme_pkg::op_type      q_op,
   output logic                 q_val,
   output logic [XW:0]          q_x0,
   output logic [XW:0]          q_x1,
   output logic [YW:0]          q_y0,
   output logic [YW:0]          q_y1,
   input  logic                 push
);
   import sme_pkg::*;

   localparam int EW = 22;

   op_type          op;
   logic            val;
   logic signed [EW-1:0] sx0, sy0, sx1, sy1, sw, sh;
   logic [XW:0]     x0, x1;
   logic [YW:0]     y0, y1;

   always_comb begin
      sw  = $signed({{(EW-XW-1){1'b0}}, eff_w});
      sh  = $signed({{(EW-YW-1){1'b0}}, eff_h});
      sx0 = EW'(pos_x);
      sy0 = EW'(pos_y);
      sx1 = sx0 + $signed({{(EW-10){1'b0}}, rect_w});
      sy1 = sy0 + $signed({{(EW-10){1'b0}}, rect_h});
      op  = OP_NOP;
      val = 1'b0;
      unique case (req_type)
         REQ_SET_RECT, REQ_CLEAR_RECT: begin
            op  = OP_FILL;
            val = (req_type == REQ_SET_RECT);
         end
         REQ_SELECT_ALL: begin
            op  = OP_FILL;
            val = 1'b1;
            sx0 = '0;
            sy0 = '0;
            sx1 = sw;
            sy1 = sh;
         end
         REQ_CLEAR_ALL: begin
            op  = OP_FILL;
            sx0 = '0;
            sy0 = '0;
            sx1 = sw;
            sy1 = sh;
         end
         REQ_QUERY_PIX: begin
            op  = OP_PIXEL;
            sx1 = sx0 + EW'(1);
            sy1 = sy0 + EW'(1);
         end
         REQ_QUERY_BOX: begin
            op  = OP_BOX;
            sx0 = '0;
            sy0 = '0;
            sx1 = sw;
            sy1 = sh;
         end
         default: op = OP_NOP;
      endcase
      if (sx0 < 0) sx0 = '0;
      if (sy0 < 0) sy0 = '0;
      if (sx1 > sw) sx1 = sw;
      if (sy1 > sh) sy1 = sh;
      if (sx1 < sx0) sx1 = sx0;
      if (sy1 < sy0) sy1 = sy0;
      if (sx0 > sw) begin
         sx0 = sw;
         sx1 = sw;
      end
      if (sy0 > sh) begin
         sy0 = sh;
         sy1 = sh;
      end
      x0 = sx0[XW:0];
      x1 = sx1[XW:0];
      y0 = sy0[YW:0];
      y1 = sy1[YW:0];
   end

   // two entry queue
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, rd_in, wr_ff, wr_in;
   op_type      op_ff [2];
   logic        val_ff [2];
   logic [XW:0] x0_ff [2], x1_ff [2];
   logic [YW:0] y0_ff [2], y1_ff [2];
   logic        enq;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign enq     = push && !q_full;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, enq} - {1'b0, deq};
      rd_in  = deq ? !rd_ff : rd_ff;
      wr_in  = enq ? !wr_ff : wr_ff;
      if (flush) begin
         cnt_in = '0;
         rd_in  = 1'b0;
         wr_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (enq) begin
         op_ff[wr_ff]  <= op;
         val_ff[wr_ff] <= val;
         x0_ff[wr_ff]  <= x0;
         x1_ff[wr_ff]  <= x1;
         y0_ff[wr_ff]  <= y0;
         y1_ff[wr_ff]  <= y1;
      end
   end

   assign q_op  = op_ff[rd_ff];
   assign q_val = val_ff[rd_ff];
   assign q_x0  = x0_ff[rd_ff];
   assign q_x1  = x1_ff[rd_ff];
   assign q_y0  = y0_ff[rd_ff];
   assign q_y1  = y1_ff[rd_ff];

   assert property (@(posedge clock) disable iff (reset) q_full |-> !(cnt_in > 2'd2))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) deq |-> q_valid)
      else $error("dequeue from empty queue");
   assert property (@(posedge clock) disable iff (reset)
         q_valid |-> (q_x0 <= q_x1 && q_y0 <= q_y1))
      else $error("bad clipped rectangle");
endmodule

>>> hdl/sme_back.sv
module sme_back #(
   parameter int XW = 8,
   parameter int YW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_req,
   input  logic [XW:0]          eff_w,
   input  logic [YW:0]          eff_h,
   input  logic                 q_valid,
   input  sme_pkg::op_type      q_op,
   input  logic                 q_val,
   input  logic [XW:0]          q_x0,
   input  logic [XW:0]          q_x1,
   input  logic [YW:0]          q_y0,
   input  logic [YW:0]          q_y1,
   output logic                 deq,
   output logic                 busy,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 pixel_selected,
   output logic                 mask_empty,
   output logic [7:0]           box_x,
   output logic [7:0]           box_y,
   output logic [8:0]           box_w,
   output logic [8:0]           box_h
);
   import sme_pkg::*;

   localparam int AW = XW + YW;

   // one bit per pixel memory, one row-major address per pixel
   logic            mem [2**AW];
   logic            rd_bit_ff;

   exec_state_type  st_ff, st_in;
   logic [AW:0]     clr_ff, clr_in;
   logic [XW-1:0]   px_ff, px_in;
   logic [YW-1:0]   py_ff, py_in;
   logic [XW:0]     x0_ff, x1_ff;
   logic [YW:0]     y0_ff, y1_ff;
   op_type          op_ff;
   logic            val_ff;
   logic            chk_ff, chk_in;
   logic [XW-1:0]   cx_ff;
   logic [YW-1:0]   cy_ff;
   logic [XW:0]     minx_ff, maxx_ff;
   logic [YW:0]     miny_ff, maxy_ff;
   logic            any_ff;
   logic            out_v_ff, out_v_in;
   logic            last_pix;
   logic            wr_en, wr_bit;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic            take;
   logic            emit;
   logic            pix_ff, mty_ff;
   logic [7:0]      bx_ff, by_ff;
   logic [8:0]      bw_ff, bh_ff;
   logic            res_pix, res_mty;
   logic [7:0]      res_bx, res_by;
   logic [8:0]      res_bw, res_bh;

   assign last_pix = ({1'b0, px_ff} + 1'b1 >= x0_ff ? ({1'b0, px_ff} + 1'b1 == x1_ff) : 1'b0)
                     && ({1'b0, py_ff} + 1'b1 == y1_ff);
   assign take = q_valid && (st_ff == ST_IDLE) && !clear_req;
   assign deq  = take;
   assign busy = (st_ff != ST_IDLE) || q_valid;
   // result register free or freed by this pop
   assign emit = (st_ff == ST_EMIT) && !chk_ff && (!out_v_ff || rsp_pop);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (clear_req)
               st_in = ST_CLEAR;
            else if (take)
               st_in = (q_op == OP_NOP || q_x0 == q_x1 || q_y0 == q_y1)
                       ? ST_EMIT : ST_WORK;
         end
         ST_CLEAR: if (clr_ff[AW]) st_in = ST_IDLE;
         ST_WORK:  if (last_pix) st_in = ST_EMIT;
         ST_EMIT:  if (emit) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
      if (clear_req) st_in = ST_CLEAR;
   end

   always_comb begin
      clr_in  = clear_req ? '0 : clr_ff + 1'b1;
      px_in   = px_ff;
      py_in   = py_ff;
      wr_en   = 1'b0;
      wr_bit  = 1'b0;
      wr_addr = {py_ff, px_ff};
      chk_in  = 1'b0;
      if (st_ff == ST_CLEAR) begin
         wr_en   = !clr_ff[AW];
         wr_addr = clr_ff[AW-1:0];
      end
      if (take) begin
         px_in = q_x0[XW-1:0];
         py_in = q_y0[YW-1:0];
      end else if (st_ff == ST_WORK) begin
         wr_en  = (op_ff == OP_FILL);
         wr_bit = val_ff;
         chk_in = (op_ff != OP_FILL);
         if ({1'b0, px_ff} + 1'b1 == x1_ff) begin
            px_in = x0_ff[XW-1:0];
            py_in = py_ff + 1'b1;
         end else begin
            px_in = px_ff + 1'b1;
         end
      end
      rd_addr = {py_ff, px_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_bit;
      rd_bit_ff <= mem[rd_addr];
   end

   always_comb begin
      out_v_in = out_v_ff;
      if (rsp_pop && out_v_ff) out_v_in = 1'b0;
      if (emit) out_v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_CLEAR;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         clr_ff   <= clr_in;
         out_v_ff <= out_v_in;
         chk_ff   <= chk_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      cx_ff <= px_ff;
      cy_ff <= py_ff;
      if (take) begin
         op_ff   <= q_op;
         val_ff  <= q_val;
         x0_ff   <= q_x0;
         x1_ff   <= q_x1;
         y0_ff   <= q_y0;
         y1_ff   <= q_y1;
         any_ff  <= 1'b0;
         minx_ff <= eff_w;
         miny_ff <= eff_h;
         maxx_ff <= '0;
         maxy_ff <= '0;
      end else if (chk_ff && rd_bit_ff) begin
         any_ff <= 1'b1;
         if ({1'b0, cx_ff} < minx_ff) minx_ff <= {1'b0, cx_ff};
         if ({1'b0, cy_ff} < miny_ff) miny_ff <= {1'b0, cy_ff};
         if ({1'b0, cx_ff} > maxx_ff || !any_ff) maxx_ff <= {1'b0, cx_ff};
         if ({1'b0, cy_ff} > maxy_ff || !any_ff) maxy_ff <= {1'b0, cy_ff};
      end
      if (emit) begin
         pix_ff <= res_pix;
         mty_ff <= res_mty;
         bx_ff  <= res_bx;
         by_ff  <= res_by;
         bw_ff  <= res_bw;
         bh_ff  <= res_bh;
      end
   end

   logic [XW:0] bw;
   logic [YW:0] bh;
   assign bw = maxx_ff - minx_ff + 1'b1;
   assign bh = maxy_ff - miny_ff + 1'b1;

   assign res_pix = (op_ff == OP_PIXEL) && any_ff;
   assign res_mty = (op_ff == OP_BOX) && !any_ff;
   assign res_bx  = (op_ff == OP_BOX && any_ff) ? 8'(minx_ff) : '0;
   assign res_by  = (op_ff == OP_BOX && any_ff) ? 8'(miny_ff) : '0;
   assign res_bw  = (op_ff == OP_BOX && any_ff) ? 9'(bw) : '0;
   assign res_bh  = (op_ff == OP_BOX && any_ff) ? 9'(bh) : '0;

   assign rsp_empty      = !out_v_ff;
   assign pixel_selected = pix_ff;
   assign mask_empty     = mty_ff;
   assign box_x          = bx_ff;
   assign box_y          = by_ff;
   assign box_w          = bw_ff;
   assign box_h          = bh_ff;

   assert property (@(posedge clock) disable iff (reset)
         (out_v_ff && !rsp_pop) |=> (out_v_ff && $stable(box_w) && $stable(box_h)))
      else $error("waiting result changed");
   assert property (@(posedge clock) disable iff (reset)
         (st_ff == ST_CLEAR) |-> rsp_empty || $past(out_v_ff))
      else $error("result raised during clear");
   assert property (@(posedge clock) disable iff (reset) wr_en |-> st_ff != ST_IDLE)
      else $error("write while idle");
endmodule

>>> hdl/selection_mask_engine.sv
// requests are processed one at a time; a fill walks its clipped rectangle,
// a pixel query one pixel, a bounds query the canvas
// reset: synchronous, active high; then the mask is cleared one pixel a cycle,
// and again after each size register write
module selection_mask_engine #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [2:0]        req_type,
   input  logic signed [9:0] pos_x,
   input  logic signed [9:0] pos_y,
   input  logic [9:0]        rect_w,
   input  logic [9:0]        rect_h,
   output logic              empty,
   input  logic              pop,
   output logic              pixel_selected,
   output logic              mask_empty,
   output logic [7:0]        box_x,
   output logic [7:0]        box_y,
   output logic [8:0]        box_w,
   output logic [8:0]        box_h,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_data
);
   import sme_pkg::*;

   localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [8:0]      cw_ff, ch_ff;
   logic [XW:0]     eff_w;
   logic [YW:0]     eff_h;
   logic            clear_req;
   logic            q_full, q_valid, q_val, deq, busy;
   op_type          q_op;
   logic [XW:0]     q_x0, q_x1;
   logic [YW:0]     q_y0, q_y1;

   assign clear_req = csr_we;
   assign eff_w = (32'(cw_ff) > MAX_WIDTH)  ? (XW+1)'(MAX_WIDTH)  : (XW+1)'(cw_ff);
   assign eff_h = (32'(ch_ff) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(ch_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= 9'd256;
         ch_ff <= 9'd256;
      end else if (csr_we) begin
         if (csr_index == 1'(CSR_WIDTH)) cw_ff <= csr_data;
         else                             ch_ff <= csr_data;
      end
   end

   assign full = q_full;

   sme_front #(.XW(XW), .YW(YW)) u_front (
      .clock, .reset, .req_type, .pos_x, .pos_y, .rect_w, .rect_h,
      .eff_w, .eff_h, .flush(1'b0), .deq, .q_full, .q_valid, .q_op, .q_val,
      .q_x0, .q_x1, .q_y0, .q_y1, .push
   );

   sme_back #(.XW(XW), .YW(YW)) u_back (
      .clock, .reset, .clear_req, .eff_w, .eff_h, .q_valid, .q_op, .q_val,
      .q_x0, .q_x1, .q_y0, .q_y1, .deq, .busy, .rsp_empty(empty), .rsp_pop(pop),
      .pixel_selected, .mask_empty, .box_x, .box_y, .box_w, .box_h
   );

   assert property (@(posedge clock) disable iff (reset) csr_we |-> !busy || empty == 1'b1)
      else $error("size write while busy");
   assert property (@(posedge clock) disable iff (reset) (eff_w <= (XW+1)'(MAX_WIDTH)))
      else $error("width out of range");
   assert property (@(posedge clock) disable iff (reset) $rose(csr_we) |=> full == full)
      else $error("full unknown");
endmodule

>>> verif/tb_selection_mask_engine.sv
`timescale 1ns / 100ps

module tb_selection_mask_engine;
   import sme_pkg::*;

   localparam int MASK_W = 256;
   localparam int MASK_H = 256;
   localparam int STALL_LIMIT = 400000;

   typedef struct {
      logic [2:0]        kind;
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic [9:0]        w;
      logic [9:0]        h;
   } mask_req_t;

   typedef struct {
      logic       pix;
      logic       none;
      logic [7:0] bx;
      logic [7:0] by;
      logic [8:0] bw;
      logic [8:0] bh;
   } mask_rsp_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [2:0]        req_type = '0;
   logic signed [9:0] pos_x = '0;
   logic signed [9:0] pos_y = '0;
   logic [9:0]        rect_w = '0;
   logic [9:0]        rect_h = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic              pixel_selected;
   logic              mask_empty;
   logic [7:0]        box_x;
   logic [7:0]        box_y;
   logic [8:0]        box_w;
   logic [8:0]        box_h;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [8:0]        csr_data = '0;

   mask_req_t pending_reqs[$];
   mask_rsp_t expected_rsps[$];
   bit        shadow_mask[MASK_W*MASK_H];
   int        canvas_w_reg = 256;
   int        canvas_h_reg = 256;
   bit        offered = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_cycles = 0;
   int        mismatches = 0;
   int        stall_count = 0;
   int        reqs_sent = 0;
   int        rsps_checked = 0;
   int        csr_writes = 0;

   selection_mask_engine i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
      .rect_w(rect_w), .rect_h(rect_h), .empty(empty), .pop(pop),
      .pixel_selected(pixel_selected), .mask_empty(mask_empty),
      .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_w();
      return canvas_w_reg > MASK_W ? MASK_W : canvas_w_reg;
   endfunction

   function automatic int eff_h();
      return canvas_h_reg > MASK_H ? MASK_H : canvas_h_reg;
   endfunction

   function automatic void fill_region(int x, int y, int w, int h, bit v);
      int x0, y0, x1, y1;
      x0 = x < 0 ? 0 : x;
      y0 = y < 0 ? 0 : y;
      x1 = x + w;
      y1 = y + h;
      if (x1 > eff_w()) x1 = eff_w();
      if (y1 > eff_h()) y1 = eff_h();
      for (int py = y0; py < y1; py++)
         for (int px = x0; px < x1; px++)
            shadow_mask[py*MASK_W + px] = v;
   endfunction

   function automatic mask_rsp_t apply_mask_req(mask_req_t r);
      mask_rsp_t res;
      int cw, ch, minx, miny, maxx, maxy;
      cw = eff_w();
      ch = eff_h();
      res = '{default: '0};
      case (r.kind)
         REQ_SET_RECT:   fill_region(r.x, r.y, r.w, r.h, 1'b1);
         REQ_CLEAR_RECT: fill_region(r.x, r.y, r.w, r.h, 1'b0);
         REQ_SELECT_ALL: fill_region(0, 0, cw, ch, 1'b1);
         REQ_CLEAR_ALL:  foreach (shadow_mask[i]) shadow_mask[i] = 1'b0;
         REQ_QUERY_PIX: begin
            if (r.x >= 0 && r.y >= 0 && int'(r.x) < cw && int'(r.y) < ch)
               res.pix = shadow_mask[int'(r.y)*MASK_W + int'(r.x)];
         end
         REQ_QUERY_BOX: begin
            minx = cw; miny = ch; maxx = -1; maxy = -1;
            for (int py = 0; py < ch; py++)
               for (int px = 0; px < cw; px++)
                  if (shadow_mask[py*MASK_W + px]) begin
                     if (px < minx) minx = px;
                     if (py < miny) miny = py;
                     if (px > maxx) maxx = px;
                     if (py > maxy) maxy = py;
                  end
            if (maxx < 0) begin
               res.none = 1'b1;
            end else begin
               res.bx = minx[7:0];
               res.by = miny[7:0];
               res.bw = 9'(maxx - minx + 1);
               res.bh = 9'(maxy - miny + 1);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && !offered) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_type <= pending_reqs[0].kind;
            pos_x    <= pending_reqs[0].x;
            pos_y    <= pending_reqs[0].y;
            rect_w   <= pending_reqs[0].w;
            rect_h   <= pending_reqs[0].h;
            push     <= 1'b1;
            offered  = 1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // response side stall control
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // acceptance, prediction and checking
   always @(posedge clock) begin
      mask_req_t r;
      mask_rsp_t e;
      bit beat;
      beat = 0;
      if (!reset && push && !full) begin
         r = '{kind: req_type, x: pos_x, y: pos_y, w: rect_w, h: rect_h};
         expected_rsps.push_back(apply_mask_req(r));
         void'(pending_reqs.pop_front());
         offered = 0;
         reqs_sent++;
         beat = 1;
      end
      if (!reset && pop && !empty) begin
         beat = 1;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat");
         end else begin
            e = expected_rsps.pop_front();
            rsps_checked++;
            if (e.pix !== pixel_selected || e.none !== mask_empty || e.bx !== box_x ||
                e.by !== box_y || e.bw !== box_w || e.bh !== box_h) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pix=%0d empty=%0d box=%0d,%0d,%0d,%0d got %0d %0d %0d,%0d,%0d,%0d",
                     e.pix, e.none, e.bx, e.by, e.bw, e.bh, pixel_selected, mask_empty,
                     box_x, box_y, box_w, box_h);
            end
         end
      end
      stall_count = beat ? 0 : stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("watchdog expired after %0d cycles without a beat", stall_count);
         $display("selection_mask_engine regression: fail");
         $finish;
      end
   end

   task automatic add_req(int kind, int x, int y, int w, int h);
      mask_req_t r;
      r.kind = 3'(kind);
      r.x = 10'(x);
      r.y = 10'(y);
      r.w = 10'(w);
      r.h = 10'(h);
      pending_reqs.push_back(r);
   endtask

   task automatic add_random_reqs(int n);
      int k, pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) k = REQ_SET_RECT;
         else if (pick < 40) k = REQ_CLEAR_RECT;
         else if (pick < 45) k = REQ_SELECT_ALL;
         else if (pick < 50) k = REQ_CLEAR_ALL;
         else if (pick < 75) k = REQ_QUERY_PIX;
         else k = REQ_QUERY_BOX;
         add_req(k,
            $urandom_range(0, 99) < 85 ? int'($urandom_range(0, eff_w() + 3)) - 2
                                       : int'($urandom_range(0, 1023)),
            $urandom_range(0, 99) < 85 ? int'($urandom_range(0, eff_h() + 3)) - 2
                                       : int'($urandom_range(0, 1023)),
            $urandom_range(0, 99) < 85 ? $urandom_range(0, eff_w() + 2) : $urandom_range(0, 512),
            $urandom_range(0, 99) < 85 ? $urandom_range(0, eff_h() + 2) : $urandom_range(0, 512));
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || offered || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(int idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx[0];
      csr_data  <= 9'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) canvas_w_reg = value & 'h1ff;
      else canvas_h_reg = value & 'h1ff;
      foreach (shadow_mask[i]) shadow_mask[i] = 1'b0;
      csr_writes++;
   endtask

   task automatic set_idle(int s, int r);
      send_idle_pct = s;
      recv_idle_pct = r;
   endtask

   initial begin
      foreach (shadow_mask[i]) shadow_mask[i] = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full size canvas after reset
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_req(REQ_QUERY_PIX, 0, 0, 0, 0);
      add_req(REQ_SET_RECT, -5, -5, 10, 10);
      add_req(REQ_SET_RECT, 250, 250, 512, 512);
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_req(REQ_QUERY_PIX, 255, 255, 0, 0);
      add_req(REQ_QUERY_PIX, -1, 0, 0, 0);
      add_req(REQ_QUERY_PIX, 256, 0, 0, 0);
      add_req(REQ_QUERY_PIX, 511, -512, 0, 0);
      add_req(REQ_SET_RECT, -512, -512, 512, 512);
      add_req(REQ_CLEAR_RECT, 0, 0, 3, 3);
      add_req(REQ_CLEAR_RECT, 250, 250, 0, 512);
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_req(6, 1, 1, 1, 1);
      add_req(7, -1, -1, 1023, 1023);
      add_req(REQ_CLEAR_ALL, 0, 0, 0, 0);
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_req(REQ_SELECT_ALL, 0, 0, 0, 0);
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_req(REQ_QUERY_PIX, 128, 128, 0, 0);
      drain();

      // oversized width, zero height
      write_csr(CSR_WIDTH, 511);
      write_csr(CSR_HEIGHT, 0);
      add_req(REQ_SELECT_ALL, 0, 0, 0, 0);
      add_req(REQ_QUERY_BOX, 0, 0, 0, 0);
      add_random_reqs(25);
      drain();

      // single pixel canvas
      write_csr(CSR_WIDTH, 1);
      write_csr(CSR_HEIGHT, 1);
      set_idle(0, 0);
      add_random_reqs(50);
      drain();

      // small canvas, all idling mixes
      write_csr(CSR_WIDTH, 8);
      write_csr(CSR_HEIGHT, 8);
      set_idle(0, 0);
      add_random_reqs(100);
      drain();
      set_idle(80, 0);
      add_random_reqs(100);
      drain();
      set_idle(0, 80);
      add_random_reqs(100);
      drain();
      set_idle(29, 29);
      add_random_reqs(100);
      drain();

      // uneven canvas with a long response hold-off
      write_csr(CSR_WIDTH, 13);
      write_csr(CSR_HEIGHT, 5);
      set_idle(0, 0);
      hold_cycles = 600;
      add_random_reqs(110);
      drain();

      repeat (20) @(negedge clock);
      $display("%0d requests and %0d responses over %0d register writes",
         reqs_sent, rsps_checked, csr_writes);
      $display("canvases 256x256, 511x0, 1x1, 8x8, 13x5 with idle, stall and back-pressure");
      if (mismatches == 0) begin
         $display("selection_mask_engine regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("selection_mask_engine regression: fail");
      end
      $finish;
   end

endmodule
